### src/ikhm_pkg.sv
// Shared types, constants and the key mixing function of the integer-keyed hash map.
// Used by the top level, the front end and the back end; depends on nothing.
package ikhm_pkg;

  localparam int NUM_BUCKETS_DEF = 256;
  localparam int NUM_ENTRIES_DEF = 256;

  localparam int MIX_S1 = 20;
  localparam int MIX_S2 = 12;
  localparam int MIX_S3 = 7;
  localparam int MIX_S4 = 4;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_PUT    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] key;
    logic [31:0] value;
  } ikhm_req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HEAD,
    ST_CMP,
    ST_POP,
    ST_INS,
    ST_CLR,
    ST_RESP
  } state_t;

  function automatic logic [31:0] mix_key(input logic [31:0] k);
    logic [31:0] h;
    h = k ^ (k >> MIX_S1) ^ (k >> MIX_S2);
    return h ^ (h >> MIX_S3) ^ (h >> MIX_S4);
  endfunction

endpackage

### src/int_key_chained_hash_map.sv
// Top level of the integer-keyed chained hash map: front end, queue and back end.
// Depends on ikhm_pkg, ikhm_front and ikhm_back.
//
// Each request (lookup, put, remove, clear) produces exactly one result transaction.
// Lookup, put and remove walk the chain of their bucket: the back end reads one link
// per cycle from entry memories with registered reads. A put of a new key then
// allocates and links the entry in ST_INS, after ST_POP when a recycled slot is taken.
// Clear empties every bucket head in turn. After reset the block empties the bucket
// heads and holds in_stall high until that pass ends. A two-entry queue lets the
// front end take up to two requests while the back end or the result side stalls.
module int_key_chained_hash_map import ikhm_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [31:0]        out_read_value,
  output logic               out_status,
  output logic [8:0]         out_entry_count
);

  localparam int BW = $clog2(NUM_BUCKETS);

  logic          busy;
  logic          q_valid;
  logic          q_pop;
  ikhm_req_t     q_req;
  logic [BW-1:0] q_bkt;

  ikhm_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_key(in_key), .in_value(in_value),
    .busy(busy), .q_valid(q_valid), .q_req(q_req), .q_bkt(q_bkt), .q_pop(q_pop)
  );

  ikhm_back #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_ENTRIES(NUM_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .q_valid(q_valid), .q_req(q_req), .q_bkt(q_bkt), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_read_value(out_read_value),
    .out_status(out_status), .out_entry_count(out_entry_count)
  );

endmodule

### src/ikhm_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Standalone; used for every table of the hash map.
module ikhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ikhm_front.sv
// Front end: accepts requests, hashes the key to a bucket and queues the request.
// Depends on ikhm_pkg for the request type and the mixing function.
module ikhm_front import ikhm_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int BW = $clog2(NUM_BUCKETS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_value,
  input  logic               busy,
  output logic               q_valid,
  output ikhm_req_t          q_req,
  output logic [BW-1:0]      q_bkt,
  input  logic               q_pop
);

  ikhm_req_t     req_r [2];
  logic [BW-1:0] bkt_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic [31:0]   mixed;
  logic [BW-1:0] bkt;

  assign in_stall = busy || (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    mixed = mix_key(in_key) & 32'(NUM_BUCKETS - 1);
    bkt   = (mixed >= 32'(NUM_BUCKETS)) ? '0 : mixed[BW-1:0];
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = req_r[rp_r];
  assign q_bkt   = bkt_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      req_r[wp_r] <= '{func: func_t'(in_func), key: in_key, value: in_value};
      bkt_r[wp_r] <= bkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/ikhm_back.sv
// Back end: walks bucket chains, updates the entry pool and registers the result.
// Depends on ikhm_pkg and ikhm_ram.
module ikhm_back import ikhm_pkg::*; #(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  localparam int BW = $clog2(NUM_BUCKETS),
  localparam int EW = $clog2(NUM_ENTRIES),
  localparam int LW = $clog2(NUM_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  input  logic          q_valid,
  input  ikhm_req_t     q_req,
  input  logic [BW-1:0] q_bkt,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_found,
  output logic [31:0]   out_read_value,
  output logic          out_status,
  output logic [8:0]    out_entry_count
);

  localparam logic [LW-1:0] LINK_NULL = LW'(NUM_ENTRIES);
  localparam logic [BW-1:0] BKT_LAST  = BW'(NUM_BUCKETS - 1);

  state_t        state_r, state_nxt;
  ikhm_req_t     req_r, req_nxt;
  logic [BW-1:0] bkt_r, bkt_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [EW-1:0] n_r, n_nxt;
  logic [LW-1:0] fsp_r, fsp_nxt;
  logic [LW-1:0] fresh_r, fresh_nxt;
  logic [LW-1:0] held_r, held_nxt;
  logic [BW-1:0] clr_r, clr_nxt;
  logic          res_found_r, res_found_nxt;
  logic [31:0]   res_rv_r, res_rv_nxt;
  logic          res_status_r, res_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_found_r, out_found_nxt;
  logic [31:0]   out_rv_r, out_rv_nxt;
  logic          out_status_r, out_status_nxt;
  logic [8:0]    out_cnt_r, out_cnt_nxt;

  logic          head_we;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [LW-1:0] head_wdata, head_rd;
  logic [EW-1:0] ent_raddr;
  logic          key_we;
  logic [31:0]   key_rd;
  logic          val_we;
  logic [EW-1:0] val_waddr;
  logic [31:0]   val_rd;
  logic          next_we;
  logic [EW-1:0] next_waddr;
  logic [LW-1:0] next_wdata, next_rd;
  logic          fs_we;
  logic [EW-1:0] fs_raddr, fs_rd;
  logic [LW-1:0] fsp_dec;

  logic hit, head_null, next_null, miss, clr_last, slot_free, pool_full;

  assign hit       = (key_rd == req_r.key);
  assign head_null = (head_rd >= LINK_NULL);
  assign next_null = (next_rd >= LINK_NULL);
  assign miss      = ((state_r == ST_HEAD) && head_null) ||
                     ((state_r == ST_CMP) && !hit && next_null);
  assign clr_last  = (clr_r == BKT_LAST);
  assign slot_free = !out_valid_r || !out_stall;
  assign pool_full = (held_r == LW'(NUM_ENTRIES));
  assign fsp_dec   = fsp_r - LW'(1);
  assign busy      = (state_r == ST_INIT);
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  ikhm_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rd)
  );
  ikhm_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(n_r), .wdata(req_r.key),
    .raddr(ent_raddr), .rdata(key_rd)
  );
  ikhm_ram #(.WIDTH(32), .DEPTH(NUM_ENTRIES)) u_val (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(req_r.value),
    .raddr(ent_raddr), .rdata(val_rd)
  );
  ikhm_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(ent_raddr), .rdata(next_rd)
  );
  ikhm_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_free (
    .clk(clk), .we(fs_we), .waddr(fsp_r[EW-1:0]), .wdata(cur_r[EW-1:0]),
    .raddr(fs_raddr), .rdata(fs_rd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) state_nxt = (q_req.func == FUNC_CLEAR) ? ST_CLR : ST_HEAD;
      end
      ST_HEAD, ST_CMP: begin
        if (miss) begin
          if (req_r.func == FUNC_PUT && !pool_full) begin
            state_nxt = (fsp_r != '0) ? ST_POP : ST_INS;
          end else begin
            state_nxt = ST_RESP;
          end
        end else if (state_r == ST_HEAD || hit) begin
          state_nxt = (state_r == ST_HEAD) ? ST_CMP : ST_RESP;
        end
      end
      ST_POP:  state_nxt = ST_INS;
      ST_INS:  state_nxt = ST_RESP;
      ST_CLR:  if (clr_last) state_nxt = ST_RESP;
      ST_RESP: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result register.
  always_comb begin
    req_nxt        = req_r;
    bkt_nxt        = bkt_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    head_nxt       = head_r;
    n_nxt          = n_r;
    fsp_nxt        = fsp_r;
    fresh_nxt      = fresh_r;
    held_nxt       = held_r;
    clr_nxt        = clr_r;
    res_found_nxt  = res_found_r;
    res_rv_nxt     = res_rv_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_rv_nxt     = out_rv_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    head_we        = 1'b0;
    head_waddr     = bkt_r;
    head_wdata     = LINK_NULL;
    head_raddr     = bkt_r;
    ent_raddr      = '0;
    key_we         = 1'b0;
    val_we         = 1'b0;
    val_waddr      = n_r;
    next_we        = 1'b0;
    next_waddr     = n_r;
    next_wdata     = head_r;
    fs_we          = 1'b0;
    fs_raddr       = fsp_dec[EW-1:0];

    case (state_r)
      ST_INIT, ST_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + BW'(1);
      end
      ST_IDLE: begin
        head_raddr     = q_bkt;
        req_nxt        = q_req;
        bkt_nxt        = q_bkt;
        clr_nxt        = '0;
        res_found_nxt  = 1'b0;
        res_rv_nxt     = '0;
        res_status_nxt = 1'b0;
        if (q_valid && q_req.func == FUNC_CLEAR) begin
          fsp_nxt   = '0;
          fresh_nxt = '0;
          held_nxt  = '0;
        end
      end
      ST_HEAD: begin
        ent_raddr = head_rd[EW-1:0];
        cur_nxt   = head_rd;
        head_nxt  = head_rd;
        prev_nxt  = LINK_NULL;
      end
      ST_CMP: begin
        ent_raddr = next_rd[EW-1:0];
        if (hit) begin
          res_found_nxt = 1'b1;
          case (req_r.func)
            FUNC_LOOKUP: res_rv_nxt = val_rd;
            FUNC_PUT: begin
              val_we    = 1'b1;
              val_waddr = cur_r[EW-1:0];
            end
            FUNC_REMOVE: begin
              res_rv_nxt = val_rd;
              if (prev_r == LINK_NULL) begin
                head_we    = 1'b1;
                head_wdata = next_rd;
              end else begin
                next_we    = 1'b1;
                next_waddr = prev_r[EW-1:0];
                next_wdata = next_rd;
              end
              fs_we    = 1'b1;
              fsp_nxt  = fsp_r + LW'(1);
              held_nxt = held_r - LW'(1);
            end
            default: ;
          endcase
        end else if (!next_null) begin
          prev_nxt = cur_r;
          cur_nxt  = next_rd;
        end
      end
      ST_POP: n_nxt = fs_rd;
      ST_INS: begin
        key_we     = 1'b1;
        val_we     = 1'b1;
        next_we    = 1'b1;
        head_we    = 1'b1;
        head_wdata = LW'(n_r);
        held_nxt   = held_r + LW'(1);
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_rv_nxt     = res_rv_r;
          out_status_nxt = res_status_r;
          out_cnt_nxt    = 9'(held_r);
        end
      end
      default: ;
    endcase

    // A put of a new key takes a recycled slot first, then a never-used one.
    if (miss && req_r.func == FUNC_PUT) begin
      if (pool_full) begin
        res_status_nxt = 1'b1;
      end else if (fsp_r != '0) begin
        fsp_nxt = fsp_dec;
      end else begin
        n_nxt     = fresh_r[EW-1:0];
        fresh_nxt = fresh_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    bkt_r        <= bkt_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    head_r       <= head_nxt;
    n_r          <= n_nxt;
    res_found_r  <= res_found_nxt;
    res_rv_r     <= res_rv_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_rv_r     <= out_rv_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      fsp_r       <= '0;
      fresh_r     <= '0;
      held_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fsp_r       <= fsp_nxt;
      fresh_r     <= fresh_nxt;
      held_r      <= held_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_read_value  = out_rv_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= LW'(NUM_ENTRIES))
    else $error("held entry count exceeds the pool size");

  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_POP && state_r != ST_INS) |-> held_r == fresh_r - fsp_r)
    else $error("held count disagrees with allocated minus recycled slots");

  a_no_pop_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !q_pop)
    else $error("request taken during the bucket clearing pass");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |=> held_r == $past(held_r) + LW'(1))
    else $error("insert did not advance the held count");

endmodule
